### hdl/multilevel_feedback_scheduler_unit_defines.svh
// Assertion macros for the multilevel feedback scheduler.
// Used by the top level only; no other dependency.
`ifndef MULTILEVEL_FEEDBACK_SCHEDULER_UNIT_DEFINES_SVH
`define MULTILEVEL_FEEDBACK_SCHEDULER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define MFS_ASSERT_IMPLY(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);
`define MFS_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`else
`define MFS_ASSERT_IMPLY(label, clk, rst_n, a, b, msg)
`define MFS_ASSERT_NEXT(label, clk, rst_n, a, b, msg)
`endif
`endif

### hdl/mfs_pkg.sv
// Shared types and codes of the multilevel feedback scheduler.
// No dependencies.
`timescale 1ns / 1ps
package mfs_pkg;

    localparam int ID_W    = 6;
    localparam int SLICE_W = 9;
    localparam int TIMER_W = 17;
    localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

    // action codes
    localparam logic [1:0] ACT_ADD      = 2'd0;
    localparam logic [1:0] ACT_SCHEDULE = 2'd1;
    localparam logic [1:0] ACT_REMOVE   = 2'd2;

    // thread class codes
    localparam logic [1:0] CLS_CRITICAL = 2'd1;
    localparam logic [1:0] CLS_IDLE     = 2'd2;

    // register indexes
    localparam logic [1:0] CFG_SLICE_BASE  = 2'd0;
    localparam logic [1:0] CFG_BOOST_LIMIT = 2'd1;
    localparam logic [1:0] CFG_IDLE_LEVEL  = 2'd2;

    typedef struct packed {
        logic [7:0]  slice_base;
        logic [15:0] boost_limit;
        logic [5:0]  idle_level;
    } cfg_t;

    typedef struct packed {
        logic link;
        logic level;
    } tmem_we_t;

    typedef struct packed {
        logic head;
        logic tail;
    } lmem_we_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ADD,
        ST_SCH_RD,
        ST_SCH_LV,
        ST_PUSH_RD,
        ST_PUSH_WR,
        ST_PUSH_LV,
        ST_TIMER,
        ST_BST_SCAN,
        ST_BST_HEAD,
        ST_BST_WALK,
        ST_BST_NEXT,
        ST_BST_L0RD,
        ST_BST_APP,
        ST_PICK_SCAN,
        ST_PICK_HEAD,
        ST_UL_RD,
        ST_UL_LV,
        ST_UL_CHK,
        ST_UL_HEAD,
        ST_UL_WALK,
        ST_UL_NEXT,
        ST_UL_FIX,
        ST_DONE
    } state_t;

    typedef struct packed {
        state_t state;
        logic   l0_nonempty;
        logic   timer_zero;
    } stat_t;

endpackage

### hdl/mfs_thread_mem.sv
// Per-thread memory: next link and level of each thread.
// One address, per-field write enables, read-first, registered read. Uses mfs_pkg.
`timescale 1ns / 1ps
module mfs_thread_mem #(
    parameter int THREADS = 64,
    parameter int LEVELS  = 62
) (
    input  logic                         clk,
    input  logic [$clog2(THREADS)-1:0]   addr,
    input  mfs_pkg::tmem_we_t            we,
    input  logic [$clog2(THREADS)-1:0]   wlink,
    input  logic [$clog2(LEVELS)-1:0]    wlevel,
    output logic [$clog2(THREADS)-1:0]   rlink,
    output logic [$clog2(LEVELS)-1:0]    rlevel
);
    localparam int TW = $clog2(THREADS);
    localparam int LW = $clog2(LEVELS);

    logic [TW-1:0] link_mem  [THREADS];
    logic [LW-1:0] level_mem [THREADS];

    // write ports
    always_ff @(posedge clk)
    begin
        if (we.link)
        begin
            link_mem[addr] <= wlink;
        end
        if (we.level)
        begin
            level_mem[addr] <= wlevel;
        end
    end

    // registered read, old data on a same-cycle write
    always_ff @(posedge clk)
    begin
        rlink  <= link_mem[addr];
        rlevel <= level_mem[addr];
    end
endmodule

### hdl/mfs_level_mem.sv
// Per-level memory: head and tail thread of each level list.
// One address, per-field write enables, read-first, registered read. Uses mfs_pkg.
`timescale 1ns / 1ps
module mfs_level_mem #(
    parameter int THREADS = 64,
    parameter int LEVELS  = 62
) (
    input  logic                         clk,
    input  logic [$clog2(LEVELS)-1:0]    addr,
    input  mfs_pkg::lmem_we_t            we,
    input  logic [$clog2(THREADS)-1:0]   whead,
    input  logic [$clog2(THREADS)-1:0]   wtail,
    output logic [$clog2(THREADS)-1:0]   rhead,
    output logic [$clog2(THREADS)-1:0]   rtail
);
    localparam int TW = $clog2(THREADS);

    logic [TW-1:0] head_mem [LEVELS];
    logic [TW-1:0] tail_mem [LEVELS];

    // write ports
    always_ff @(posedge clk)
    begin
        if (we.head)
        begin
            head_mem[addr] <= whead;
        end
        if (we.tail)
        begin
            tail_mem[addr] <= wtail;
        end
    end

    // registered read
    always_ff @(posedge clk)
    begin
        rhead <= head_mem[addr];
        rtail <= tail_mem[addr];
    end
endmodule

### hdl/mfs_ctrl.sv
// Sequencer of the scheduler: list walks, boost, pick and the result register.
// Drives both memories. Uses mfs_pkg.
`timescale 1ns / 1ps
module mfs_ctrl #(
    parameter int THREADS = 64,
    parameter int LEVELS  = 62
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   action,
    input  logic [5:0]                   thread_id,
    input  logic                         thread_present,
    input  logic                         preemptive,
    input  logic [1:0]                   thread_class,
    input  mfs_pkg::cfg_t                cfg,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [5:0]                   next_thread,
    output logic                         next_valid,
    output logic [8:0]                   time_slice,
    output logic                         status,
    output logic [$clog2(THREADS)-1:0]   t_addr,
    output mfs_pkg::tmem_we_t            t_we,
    output logic [$clog2(THREADS)-1:0]   t_wlink,
    output logic [$clog2(LEVELS)-1:0]    t_wlevel,
    input  logic [$clog2(THREADS)-1:0]   t_rlink,
    input  logic [$clog2(LEVELS)-1:0]    t_rlevel,
    output logic [$clog2(LEVELS)-1:0]    l_addr,
    output mfs_pkg::lmem_we_t            l_we,
    output logic [$clog2(THREADS)-1:0]   l_whead,
    output logic [$clog2(THREADS)-1:0]   l_wtail,
    input  logic [$clog2(THREADS)-1:0]   l_rhead,
    input  logic [$clog2(THREADS)-1:0]   l_rtail,
    output mfs_pkg::stat_t               stat
);
    localparam int TW = $clog2(THREADS);
    localparam int LW = $clog2(LEVELS);
    localparam logic [LW-1:0] CRIT = LW'(LEVELS - 1);
    localparam logic [LW:0]   LEVELS_N = (LW+1)'(LEVELS);

    mfs_pkg::state_t state_reg, state_next;

    logic [1:0]    act_reg;
    logic [5:0]    tid_reg;
    logic          pres_reg, pre_reg;
    logic [1:0]    cls_reg;
    logic [TW-1:0] ut_reg, ut_next;
    logic [LW-1:0] lv_reg, lv_next;
    logic [LW-1:0] tgt_reg, tgt_next;
    logic [TW-1:0] cur_reg, cur_next;
    logic [TW-1:0] prev_reg, prev_next;
    logic [TW-1:0] head_reg, head_next;
    logic [TW-1:0] tail_reg, tail_next;
    logic          hasprev_reg, hasprev_next;
    logic          pick_reg, pick_next;
    logic          found_reg, found_next;
    logic [LW:0]   idx_reg, idx_next;
    logic [8:0]    slice_reg, slice_next;
    logic [mfs_pkg::TIMER_W-1:0] timer_reg, timer_next;
    logic [THREADS-1:0] queued_reg, queued_next;
    logic [LEVELS-1:0]  nonempty_reg, nonempty_next;
    logic [5:0]    res_thread_reg, res_thread_next;
    logic          res_valid_reg, res_valid_next;
    logic [8:0]    res_slice_reg, res_slice_next;
    logic          ovalid_reg, ovalid_next;
    logic [5:0]    othread_reg;
    logic          onext_reg;
    logic [8:0]    oslice_reg;
    logic          ostatus_reg;

    logic          accept;
    logic          tid_ok;
    logic          out_free;
    logic [LW-1:0] rd_lv_clamp;
    logic [LW-1:0] idle_clamp;
    logic [17:0]   timer_sum;
    logic [mfs_pkg::TIMER_W-1:0] timer_sat;
    logic          ul_ok;
    logic          pick_here, bst_here;

    assign accept    = in_valid && (state_reg == mfs_pkg::ST_IDLE);
    assign in_stall  = (state_reg != mfs_pkg::ST_IDLE);
    assign tid_ok    = (int'(tid_reg) < THREADS);
    assign out_free  = !ovalid_reg || !out_stall;
    assign rd_lv_clamp = (int'(t_rlevel) >= LEVELS) ? CRIT : t_rlevel;
    assign idle_clamp  = (int'(cfg.idle_level) < LEVELS) ? LW'(cfg.idle_level) : CRIT;
    assign timer_sum = {1'b0, timer_reg} + 18'(slice_reg);
    assign timer_sat = timer_sum[17] ? mfs_pkg::TIMER_MAX : timer_sum[16:0];
    assign ul_ok     = queued_reg[ut_reg] && ({1'b0, lv_reg} < LEVELS_N) && nonempty_reg[lv_reg];
    assign pick_here = (idx_reg != LEVELS_N) && nonempty_reg[idx_reg[LW-1:0]];
    assign bst_here  = nonempty_reg[idx_reg[LW-1:0]];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mfs_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (action)
                        mfs_pkg::ACT_ADD:      state_next = mfs_pkg::ST_ADD;
                        mfs_pkg::ACT_SCHEDULE: state_next = mfs_pkg::ST_SCH_RD;
                        mfs_pkg::ACT_REMOVE:
                            state_next = (int'(thread_id) < THREADS) ? mfs_pkg::ST_UL_RD
                                                                     : mfs_pkg::ST_DONE;
                        default:               state_next = mfs_pkg::ST_DONE;
                    endcase
                end
            end
            mfs_pkg::ST_ADD:
            begin
                if (!tid_ok)
                    state_next = mfs_pkg::ST_DONE;
                else if (queued_reg[ut_reg])
                    state_next = mfs_pkg::ST_UL_RD;
                else
                    state_next = mfs_pkg::ST_PUSH_RD;
            end
            mfs_pkg::ST_SCH_RD:
                state_next = (pres_reg && tid_ok) ? mfs_pkg::ST_SCH_LV : mfs_pkg::ST_TIMER;
            mfs_pkg::ST_SCH_LV:
                state_next = queued_reg[ut_reg] ? mfs_pkg::ST_UL_RD : mfs_pkg::ST_PUSH_RD;
            mfs_pkg::ST_PUSH_RD:  state_next = mfs_pkg::ST_PUSH_WR;
            mfs_pkg::ST_PUSH_WR:  state_next = mfs_pkg::ST_PUSH_LV;
            mfs_pkg::ST_PUSH_LV:
                state_next = (act_reg == mfs_pkg::ACT_ADD) ? mfs_pkg::ST_DONE : mfs_pkg::ST_TIMER;
            mfs_pkg::ST_TIMER:
                state_next = (timer_sat >= {1'b0, cfg.boost_limit}) ? mfs_pkg::ST_BST_SCAN
                                                                     : mfs_pkg::ST_PICK_SCAN;
            mfs_pkg::ST_BST_SCAN:
            begin
                if (idx_reg[LW-1:0] >= CRIT)
                    state_next = mfs_pkg::ST_PICK_SCAN;
                else if (bst_here)
                    state_next = mfs_pkg::ST_BST_HEAD;
            end
            mfs_pkg::ST_BST_HEAD: state_next = mfs_pkg::ST_BST_WALK;
            mfs_pkg::ST_BST_WALK:
                state_next = (cur_reg == tail_reg) ? mfs_pkg::ST_BST_L0RD : mfs_pkg::ST_BST_NEXT;
            mfs_pkg::ST_BST_NEXT: state_next = mfs_pkg::ST_BST_WALK;
            mfs_pkg::ST_BST_L0RD: state_next = mfs_pkg::ST_BST_APP;
            mfs_pkg::ST_BST_APP:  state_next = mfs_pkg::ST_BST_SCAN;
            mfs_pkg::ST_PICK_SCAN:
            begin
                if (idx_reg == LEVELS_N)
                    state_next = mfs_pkg::ST_DONE;
                else if (pick_here)
                    state_next = mfs_pkg::ST_PICK_HEAD;
            end
            mfs_pkg::ST_PICK_HEAD: state_next = mfs_pkg::ST_UL_CHK;
            mfs_pkg::ST_UL_RD:     state_next = mfs_pkg::ST_UL_LV;
            mfs_pkg::ST_UL_LV:     state_next = mfs_pkg::ST_UL_CHK;
            mfs_pkg::ST_UL_CHK:
            begin
                if (ul_ok)
                    state_next = mfs_pkg::ST_UL_HEAD;
                else if (act_reg == mfs_pkg::ACT_REMOVE || pick_reg)
                    state_next = mfs_pkg::ST_DONE;
                else
                    state_next = mfs_pkg::ST_PUSH_RD;
            end
            mfs_pkg::ST_UL_HEAD:   state_next = mfs_pkg::ST_UL_WALK;
            mfs_pkg::ST_UL_WALK:
            begin
                if (cur_reg == ut_reg && cur_reg != tail_reg)
                    state_next = mfs_pkg::ST_UL_FIX;
                else if (cur_reg == ut_reg || cur_reg == tail_reg)
                    state_next = (act_reg == mfs_pkg::ACT_REMOVE || pick_reg)
                                 ? mfs_pkg::ST_DONE : mfs_pkg::ST_PUSH_RD;
                else
                    state_next = mfs_pkg::ST_UL_NEXT;
            end
            mfs_pkg::ST_UL_NEXT:   state_next = mfs_pkg::ST_UL_WALK;
            mfs_pkg::ST_UL_FIX:
                state_next = (act_reg == mfs_pkg::ACT_REMOVE || pick_reg)
                             ? mfs_pkg::ST_DONE : mfs_pkg::ST_PUSH_RD;
            mfs_pkg::ST_DONE:
                if (out_free)
                    state_next = mfs_pkg::ST_IDLE;
            default: state_next = mfs_pkg::ST_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        ut_next         = ut_reg;
        lv_next         = lv_reg;
        tgt_next        = tgt_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        hasprev_next    = hasprev_reg;
        pick_next       = pick_reg;
        found_next      = found_reg;
        idx_next        = idx_reg;
        slice_next      = slice_reg;
        timer_next      = timer_reg;
        queued_next     = queued_reg;
        nonempty_next   = nonempty_reg;
        res_thread_next = res_thread_reg;
        res_valid_next  = res_valid_reg;
        res_slice_next  = res_slice_reg;
        ovalid_next     = ovalid_reg && out_stall;
        t_addr   = ut_reg;
        t_we     = '0;
        t_wlink  = ut_reg;
        t_wlevel = tgt_reg;
        l_addr   = tgt_reg;
        l_we     = '0;
        l_whead  = ut_reg;
        l_wtail  = ut_reg;
        unique case (state_reg)
            mfs_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    ut_next         = TW'(thread_id);
                    pick_next       = 1'b0;
                    found_next      = 1'b0;
                    res_thread_next = '0;
                    res_valid_next  = 1'b0;
                    res_slice_next  = '0;
                    slice_next      = 9'(cfg.slice_base);
                end
            end
            mfs_pkg::ST_ADD:
            begin
                if (cls_reg == mfs_pkg::CLS_CRITICAL)
                    tgt_next = CRIT;
                else if (cls_reg == mfs_pkg::CLS_IDLE)
                    tgt_next = idle_clamp;
                else
                    tgt_next = '0;
            end
            mfs_pkg::ST_SCH_RD:
                t_addr = ut_reg;
            mfs_pkg::ST_SCH_LV:
            begin
                // slice from the level before demotion
                slice_next = {rd_lv_clamp, 1'b0} + 9'(cfg.slice_base);
                if (pre_reg && (int'(rd_lv_clamp) < LEVELS - 2))
                    tgt_next = rd_lv_clamp + 1'b1;
                else
                    tgt_next = rd_lv_clamp;
            end
            mfs_pkg::ST_PUSH_RD:
                l_addr = tgt_reg;
            mfs_pkg::ST_PUSH_WR:
            begin
                l_addr  = tgt_reg;
                l_we.tail = 1'b1;
                l_we.head = !nonempty_reg[tgt_reg];
                t_addr  = l_rtail;
                t_wlink = ut_reg;
                t_we.link = nonempty_reg[tgt_reg];
                nonempty_next[tgt_reg] = 1'b1;
                queued_next[ut_reg]    = 1'b1;
            end
            mfs_pkg::ST_PUSH_LV:
            begin
                t_addr     = ut_reg;
                t_wlevel   = tgt_reg;
                t_we.level = 1'b1;
            end
            mfs_pkg::ST_TIMER:
            begin
                if (timer_sat >= {1'b0, cfg.boost_limit})
                begin
                    timer_next = '0;
                    idx_next   = (LW+1)'(1);
                end
                else
                begin
                    timer_next = timer_sat;
                    idx_next   = '0;
                end
            end
            mfs_pkg::ST_BST_SCAN:
            begin
                l_addr = idx_reg[LW-1:0];
                if (idx_reg[LW-1:0] >= CRIT)
                    idx_next = '0;
                else if (!bst_here)
                    idx_next = idx_reg + 1'b1;
            end
            mfs_pkg::ST_BST_HEAD:
            begin
                head_next = l_rhead;
                tail_next = l_rtail;
                cur_next  = l_rhead;
            end
            mfs_pkg::ST_BST_WALK:
            begin
                // relabel the thread as level zero and fetch its link
                t_addr     = cur_reg;
                t_wlevel   = '0;
                t_we.level = 1'b1;
            end
            mfs_pkg::ST_BST_NEXT:
                cur_next = t_rlink;
            mfs_pkg::ST_BST_L0RD:
                l_addr = '0;
            mfs_pkg::ST_BST_APP:
            begin
                l_addr    = '0;
                l_whead   = head_reg;
                l_wtail   = tail_reg;
                l_we.tail = 1'b1;
                l_we.head = !nonempty_reg[0];
                t_addr    = l_rtail;
                t_wlink   = head_reg;
                t_we.link = nonempty_reg[0];
                nonempty_next[0] = 1'b1;
                nonempty_next[idx_reg[LW-1:0]] = 1'b0;
                idx_next = idx_reg + 1'b1;
            end
            mfs_pkg::ST_PICK_SCAN:
            begin
                l_addr = idx_reg[LW-1:0];
                if (idx_reg != LEVELS_N && !pick_here)
                    idx_next = idx_reg + 1'b1;
            end
            mfs_pkg::ST_PICK_HEAD:
            begin
                res_thread_next = 6'(l_rhead);
                res_valid_next  = 1'b1;
                res_slice_next  = {idx_reg[LW-1:0], 1'b0} + 9'(cfg.slice_base);
                t_addr     = l_rhead;
                t_wlevel   = idx_reg[LW-1:0];
                t_we.level = 1'b1;
                ut_next    = l_rhead;
                lv_next    = idx_reg[LW-1:0];
                pick_next  = 1'b1;
            end
            mfs_pkg::ST_UL_RD:
                t_addr = ut_reg;
            mfs_pkg::ST_UL_LV:
                lv_next = t_rlevel;
            mfs_pkg::ST_UL_CHK:
                l_addr = lv_reg;
            mfs_pkg::ST_UL_HEAD:
            begin
                cur_next     = l_rhead;
                tail_next    = l_rtail;
                hasprev_next = 1'b0;
            end
            mfs_pkg::ST_UL_WALK:
            begin
                t_addr = cur_reg;
                l_addr = lv_reg;
                if (cur_reg == ut_reg)
                begin
                    if (cur_reg == tail_reg)
                    begin
                        // last in list: move the tail back or empty the level
                        l_wtail   = prev_reg;
                        l_we.tail = hasprev_reg;
                        if (!hasprev_reg)
                            nonempty_next[lv_reg] = 1'b0;
                        queued_next[ut_reg] = 1'b0;
                        found_next = 1'b1;
                    end
                end
                else if (cur_reg != tail_reg)
                begin
                    prev_next    = cur_reg;
                    hasprev_next = 1'b1;
                end
            end
            mfs_pkg::ST_UL_NEXT:
                cur_next = t_rlink;
            mfs_pkg::ST_UL_FIX:
            begin
                // bypass the thread: fix the predecessor link or the head
                l_addr    = lv_reg;
                l_whead   = t_rlink;
                l_we.head = !hasprev_reg;
                t_addr    = prev_reg;
                t_wlink   = t_rlink;
                t_we.link = hasprev_reg;
                queued_next[ut_reg] = 1'b0;
                found_next = 1'b1;
            end
            mfs_pkg::ST_DONE:
            begin
                if (out_free)
                    ovalid_next = 1'b1;
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= mfs_pkg::ST_IDLE;
            queued_reg   <= '0;
            nonempty_reg <= '0;
            timer_reg    <= '0;
            ovalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            queued_reg   <= queued_next;
            nonempty_reg <= nonempty_next;
            timer_reg    <= timer_next;
            ovalid_reg   <= ovalid_next;
        end
    end

    // working and payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg  <= action;
            tid_reg  <= thread_id;
            pres_reg <= thread_present;
            pre_reg  <= preemptive;
            cls_reg  <= thread_class;
        end
        ut_reg         <= ut_next;
        lv_reg         <= lv_next;
        tgt_reg        <= tgt_next;
        cur_reg        <= cur_next;
        prev_reg       <= prev_next;
        head_reg       <= head_next;
        tail_reg       <= tail_next;
        hasprev_reg    <= hasprev_next;
        pick_reg       <= pick_next;
        found_reg      <= found_next;
        idx_reg        <= idx_next;
        slice_reg      <= slice_next;
        res_thread_reg <= res_thread_next;
        res_valid_reg  <= res_valid_next;
        res_slice_reg  <= res_slice_next;
        if (state_reg == mfs_pkg::ST_DONE && out_free)
        begin
            othread_reg <= res_thread_reg;
            onext_reg   <= res_valid_reg;
            oslice_reg  <= res_slice_reg;
            ostatus_reg <= (act_reg == mfs_pkg::ACT_REMOVE) && !found_reg;
        end
    end

    assign out_valid   = ovalid_reg;
    assign next_thread = othread_reg;
    assign next_valid  = onext_reg;
    assign time_slice  = oslice_reg;
    assign status      = ostatus_reg;

    assign stat.state       = state_reg;
    assign stat.l0_nonempty = nonempty_reg[0];
    assign stat.timer_zero  = (timer_reg == '0);
endmodule

### hdl/multilevel_feedback_scheduler_unit.sv
// Top level of the multilevel feedback scheduler: config registers, sequencer, memories.
// Depends on mfs_pkg, mfs_ctrl, mfs_thread_mem, mfs_level_mem and the defines header.
//
//   channel  signals                          role
//   in       in_valid / in_stall, 5 fields     action item in
//   out      out_valid / out_stall, 4 fields   one result item per input item
//   cfg      cfg_we, cfg_index, cfg_data       register write, no read-back
//
// One item at a time, taken only while the sequencer idles; one memory port per store.
// Add unlinks the thread first when it is already queued, walking the list entries ahead.
// Remove walks the list entries ahead of the thread. Schedule requeues the thread, scans
// the levels for the pick and, on a boost, scans levels 1..LEVELS-2 and moves every
// thread of each non-empty level to level 0. Reset clears the flags, no clearing pass.
// A finished result waits in the output register while the next item is taken.
`timescale 1ns / 1ps
`include "multilevel_feedback_scheduler_unit_defines.svh"
module multilevel_feedback_scheduler_unit #(
    parameter int THREADS = 64,
    parameter int LEVELS  = 62
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [5:0]  thread_id,
    input  logic        thread_present,
    input  logic        preemptive,
    input  logic [1:0]  thread_class,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [5:0]  next_thread,
    output logic        next_valid,
    output logic [8:0]  time_slice,
    output logic        status,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    localparam int TW = $clog2(THREADS);
    localparam int LW = $clog2(LEVELS);

    mfs_pkg::cfg_t     cfg_reg;
    mfs_pkg::tmem_we_t t_we;
    mfs_pkg::lmem_we_t l_we;
    mfs_pkg::stat_t    stat;
    logic [TW-1:0] t_addr, t_wlink, t_rlink;
    logic [LW-1:0] t_wlevel, t_rlevel;
    logic [LW-1:0] l_addr;
    logic [TW-1:0] l_whead, l_wtail, l_rhead, l_rtail;
    logic          at_done, at_bst_app, at_bst_scan;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slice_base  <= 8'd10;
            cfg_reg.boost_limit <= 16'd1000;
            cfg_reg.idle_level  <= 6'd60;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mfs_pkg::CFG_SLICE_BASE:  cfg_reg.slice_base  <= cfg_data[7:0];
                mfs_pkg::CFG_BOOST_LIMIT: cfg_reg.boost_limit <= cfg_data;
                mfs_pkg::CFG_IDLE_LEVEL:  cfg_reg.idle_level  <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    mfs_ctrl #(.THREADS(THREADS), .LEVELS(LEVELS)) u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .action(action), .thread_id(thread_id), .thread_present(thread_present),
        .preemptive(preemptive), .thread_class(thread_class),
        .cfg(cfg_reg),
        .out_valid(out_valid), .out_stall(out_stall),
        .next_thread(next_thread), .next_valid(next_valid),
        .time_slice(time_slice), .status(status),
        .t_addr(t_addr), .t_we(t_we), .t_wlink(t_wlink), .t_wlevel(t_wlevel),
        .t_rlink(t_rlink), .t_rlevel(t_rlevel),
        .l_addr(l_addr), .l_we(l_we), .l_whead(l_whead), .l_wtail(l_wtail),
        .l_rhead(l_rhead), .l_rtail(l_rtail),
        .stat(stat)
    );

    mfs_thread_mem #(.THREADS(THREADS), .LEVELS(LEVELS)) u_tmem (
        .clk(clk), .addr(t_addr), .we(t_we), .wlink(t_wlink), .wlevel(t_wlevel),
        .rlink(t_rlink), .rlevel(t_rlevel)
    );

    mfs_level_mem #(.THREADS(THREADS), .LEVELS(LEVELS)) u_lmem (
        .clk(clk), .addr(l_addr), .we(l_we), .whead(l_whead), .wtail(l_wtail),
        .rhead(l_rhead), .rtail(l_rtail)
    );

    // state decodes for the checks
    assign at_done     = (stat.state == mfs_pkg::ST_DONE);
    assign at_bst_app  = (stat.state == mfs_pkg::ST_BST_APP);
    assign at_bst_scan = (stat.state == mfs_pkg::ST_BST_SCAN);

    // checks
    `MFS_ASSERT_IMPLY(a_out_done, clk, rst_n, $rose(out_valid), $past(at_done), "stray result")
    `MFS_ASSERT_NEXT(a_boost_l0, clk, rst_n, at_bst_app, stat.l0_nonempty, "level 0 left empty")
    `MFS_ASSERT_IMPLY(a_timer_clr, clk, rst_n, at_bst_scan, stat.timer_zero, "timer not cleared")
endmodule

### tb/sv/testbench.sv
// Self-checking testbench for the multilevel feedback scheduler unit.
// Depends on mfs_pkg and multilevel_feedback_scheduler_unit; predicts each result in-line.
`timescale 1ns / 1ps
module testbench;

    localparam int NLEV  = 62;
    localparam int NTHR  = 64;
    localparam int CRIT  = NLEV - 1;
    localparam int WDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES = 300;
    // action code with no function
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0] act;
        logic [5:0] tid;
        logic       pres;
        logic       pre;
        logic [1:0] cls;
    } sched_req_t;

    typedef struct packed {
        logic [5:0] thr;
        logic       nv;
        logic [8:0] slc;
        logic       st;
    } sched_res_t;

    logic clk, rst_n;
    logic in_valid, in_stall, out_valid, out_stall;
    logic [1:0] action, thread_class;
    logic [5:0] thread_id, next_thread;
    logic thread_present, preemptive, next_valid, status;
    logic [8:0] time_slice;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [15:0] cfg_data;

    multilevel_feedback_scheduler_unit uut (.*);

    // scheduler shadow state
    int  q_link [NTHR];
    int  q_lvl  [NTHR];
    bit  q_on   [NTHR];
    int  l_head [NLEV];
    int  l_tail [NLEV];
    bit  l_busy [NLEV];
    int  boost_acc;
    int  m_slice_base, m_boost_limit, m_idle_level;

    sched_req_t pending_reqs[$];
    sched_res_t expected_res[$];
    int  fail_count = 0;
    bit  hold_req = 0;
    bit  hold_taken;
    int  hold_off;
    int  gap_in, gap_out;

    // clock
    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    function automatic void shadow_reset();
        foreach (q_on[i])
        begin
            q_on[i] = 0;
            q_lvl[i] = 0;
            q_link[i] = 0;
        end
        foreach (l_busy[i])
        begin
            l_busy[i] = 0;
            l_head[i] = 0;
            l_tail[i] = 0;
        end
        boost_acc = 0;
        m_slice_base = 10;
        m_boost_limit = 1000;
        m_idle_level = 60;
    endfunction

    function automatic void enqueue(int lv, int t);
        if (l_busy[lv]) q_link[l_tail[lv]] = t;
        else l_head[lv] = t;
        l_tail[lv] = t;
        l_busy[lv] = 1;
        q_on[t] = 1;
        q_lvl[t] = lv;
    endfunction

    function automatic bit dequeue(int t);
        int lv, cur, prev, n;
        bit has_prev;
        lv = q_lvl[t];
        has_prev = 0;
        prev = 0;
        if (!q_on[t] || lv >= NLEV || !l_busy[lv]) return 0;
        cur = l_head[lv];
        for (n = 0; n < NTHR; n++)
        begin
            if (cur == t)
            begin
                if (cur == l_tail[lv])
                begin
                    if (has_prev) l_tail[lv] = prev;
                    else l_busy[lv] = 0;
                end
                else if (has_prev) q_link[prev] = q_link[cur];
                else l_head[lv] = q_link[cur];
                q_on[t] = 0;
                return 1;
            end
            if (cur == l_tail[lv]) break;
            prev = cur;
            has_prev = 1;
            cur = q_link[cur];
        end
        return 0;
    endfunction

    function automatic void boost_levels();
        int cur, n;
        for (int i = 1; i < CRIT; i++)
        begin
            if (!l_busy[i]) continue;
            cur = l_head[i];
            for (n = 0; n < NTHR; n++)
            begin
                q_lvl[cur] = 0;
                if (cur == l_tail[i]) break;
                cur = q_link[cur];
            end
            if (l_busy[0]) q_link[l_tail[0]] = l_head[i];
            else l_head[0] = l_head[i];
            l_tail[0] = l_tail[i];
            l_busy[0] = 1;
            l_busy[i] = 0;
        end
    endfunction

    // compute the result of one scheduler action and update the shadow state
    function automatic sched_res_t predict_schedule(sched_req_t r);
        sched_res_t o;
        int lv, slc, h;
        o = '0;
        if (r.act == mfs_pkg::ACT_ADD)
        begin
            if (r.cls == mfs_pkg::CLS_CRITICAL) lv = CRIT;
            else if (r.cls == mfs_pkg::CLS_IDLE)
                lv = (m_idle_level < NLEV) ? m_idle_level : NLEV - 1;
            else lv = 0;
            if (q_on[r.tid]) void'(dequeue(r.tid));
            enqueue(lv, r.tid);
        end
        else if (r.act == mfs_pkg::ACT_REMOVE)
        begin
            if (!dequeue(r.tid)) o.st = 1;
        end
        else if (r.act == mfs_pkg::ACT_SCHEDULE)
        begin
            if (r.pres)
            begin
                lv = q_lvl[r.tid];
                if (lv >= NLEV) lv = NLEV - 1;
                slc = lv * 2 + m_slice_base;
                if (q_on[r.tid]) void'(dequeue(r.tid));
                if (r.pre && lv < CRIT - 1) lv++;
                enqueue(lv, r.tid);
            end
            else slc = m_slice_base;
            boost_acc += slc;
            if (boost_acc > 131071) boost_acc = 131071;
            if (boost_acc >= m_boost_limit)
            begin
                boost_levels();
                boost_acc = 0;
            end
            for (int i = 0; i < NLEV; i++)
            begin
                if (l_busy[i])
                begin
                    h = l_head[i];
                    q_lvl[h] = i;
                    void'(dequeue(h));
                    o.thr = 6'(h);
                    o.nv = 1;
                    o.slc = 9'(i * 2 + m_slice_base);
                    break;
                end
            end
        end
        return o;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    // random gap: mostly short, a few long
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 0;
            gap_in <= 0;
            {action, thread_id, thread_present, preemptive, thread_class} <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
                void'(pending_reqs.pop_front());
            if (in_valid && in_stall)
            begin
                // hold the item
            end
            else if (gap_in > 0)
            begin
                gap_in <= gap_in - 1;
                in_valid <= 0;
            end
            else
            begin
                // the queue head is now the item after any one just accepted
                if (pending_reqs.size() > 0)
                begin
                    {action, thread_id, thread_present, preemptive, thread_class}
                        <= pending_reqs[0];
                    in_valid <= 1;
                end
                else in_valid <= 0;
                if (in_valid && !in_stall) gap_in <= pick_gap();
            end
        end
    end

    // receiver stall and long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 0;
            hold_off <= 0;
            hold_taken <= 0;
            gap_out <= 0;
        end
        else if (hold_req && !hold_taken)
        begin
            hold_taken <= 1;
            hold_off <= HOLD_CYCLES;
            out_stall <= 1;
        end
        else if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            out_stall <= 1;
        end
        else if (gap_out > 0)
        begin
            gap_out <= gap_out - 1;
            out_stall <= 1;
        end
        else
        begin
            out_stall <= 0;
            if (out_valid && !out_stall) gap_out <= pick_gap();
        end
    end

    // monitor: predictions are taken in acceptance order at the input
    always @(posedge clk)
    begin
        sched_res_t want;
        if (rst_n && in_valid && !in_stall)
            expected_res.push_back(predict_schedule(
                {action, thread_id, thread_present, preemptive, thread_class}));
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_res.size() == 0) report_mismatch("unexpected result", 1, 0);
            else
            begin
                want = expected_res.pop_front();
                if (next_thread !== want.thr)
                    report_mismatch("next_thread", next_thread, want.thr);
                if (next_valid !== want.nv)
                    report_mismatch("next_valid", next_valid, want.nv);
                if (time_slice !== want.slc)
                    report_mismatch("time_slice", time_slice, want.slc);
                if (status !== want.st)
                    report_mismatch("status", status, want.st);
            end
        end
    end

    // watchdog on cycles without any handshake or hold-off
    int idle_cycles = 0;
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || hold_off > 0)
            idle_cycles <= 0;
        else if (pending_reqs.size() > 0 || expected_res.size() > 0)
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WDOG_LIMIT)
            begin
                $display("Timeout waiting for handshake");
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [1:0] idx, int val);
        @(posedge clk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= 16'(val);
        @(posedge clk);
        cfg_we <= 0;
        if (idx == mfs_pkg::CFG_SLICE_BASE) m_slice_base = val & 8'hff;
        else if (idx == mfs_pkg::CFG_BOOST_LIMIT) m_boost_limit = val & 16'hffff;
        else if (idx == mfs_pkg::CFG_IDLE_LEVEL) m_idle_level = val & 6'h3f;
    endtask

    task automatic drain();
        while (pending_reqs.size() > 0 || expected_res.size() > 0) @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    function automatic void push_req(int a, int t, int p, int pr, int c);
        sched_req_t r;
        r.act = 2'(a);
        r.tid = 6'(t);
        r.pres = 1'(p);
        r.pre = 1'(pr);
        r.cls = 2'(c);
        pending_reqs.push_back(r);
    endfunction

    // random phase; only threads already added are given as outgoing
    bit ever_added [NTHR];
    task automatic random_phase(int n);
        int t, a;
        for (int k = 0; k < n; k++)
        begin
            a = $urandom_range(0, 99);
            t = $urandom_range(0, 63);
            if (a < 35)
            begin
                push_req(mfs_pkg::ACT_ADD, t, $urandom_range(0, 1), $urandom_range(0, 1),
                         $urandom_range(0, 3));
                ever_added[t] = 1;
            end
            else if (a < 75)
            begin
                if (ever_added[t])
                    push_req(mfs_pkg::ACT_SCHEDULE, t, $urandom_range(0, 1),
                             $urandom_range(0, 1), $urandom_range(0, 3));
                else
                    push_req(mfs_pkg::ACT_SCHEDULE, t, 0, $urandom_range(0, 1),
                             $urandom_range(0, 3));
            end
            else if (a < 95)
                push_req(mfs_pkg::ACT_REMOVE, t, $urandom_range(0, 1), $urandom_range(0, 1),
                         $urandom_range(0, 3));
            else
                push_req(ACT_UNUSED, t, $urandom_range(0, 1), $urandom_range(0, 1),
                         $urandom_range(0, 3));
        end
    endtask

    initial
    begin
        rst_n = 0;
        cfg_we = 0;
        cfg_index = '0;
        cfg_data = '0;
        shadow_reset();
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: empty schedule, every class, extremes, unqueued remove
        push_req(mfs_pkg::ACT_SCHEDULE, 0, 0, 0, 0);
        push_req(mfs_pkg::ACT_REMOVE, 63, 0, 0, 0);
        push_req(mfs_pkg::ACT_ADD, 0, 0, 0, 0);
        push_req(mfs_pkg::ACT_ADD, 63, 1, 1, 1);
        push_req(mfs_pkg::ACT_ADD, 5, 0, 0, 2);
        push_req(mfs_pkg::ACT_ADD, 7, 0, 0, 3);
        push_req(mfs_pkg::ACT_ADD, 0, 0, 0, 2);
        push_req(mfs_pkg::ACT_REMOVE, 7, 0, 0, 0);
        push_req(mfs_pkg::ACT_REMOVE, 7, 0, 0, 0);
        push_req(mfs_pkg::ACT_SCHEDULE, 0, 1, 1, 0);
        push_req(mfs_pkg::ACT_SCHEDULE, 63, 1, 1, 0);
        push_req(mfs_pkg::ACT_SCHEDULE, 5, 1, 0, 0);
        push_req(ACT_UNUSED, 42, 1, 1, 3);
        push_req(mfs_pkg::ACT_ADD, 42, 0, 0, 0);
        push_req(mfs_pkg::ACT_SCHEDULE, 42, 1, 1, 0);
        for (int i = 0; i < 6; i++) push_req(mfs_pkg::ACT_SCHEDULE, 42, 1, 1, 0);
        ever_added[0] = 1;
        ever_added[5] = 1;
        ever_added[7] = 1;
        ever_added[42] = 1;
        ever_added[63] = 1;
        drain();

        // extreme settings, small boost limit
        write_reg(mfs_pkg::CFG_SLICE_BASE, 255);
        write_reg(mfs_pkg::CFG_BOOST_LIMIT, 1);
        write_reg(mfs_pkg::CFG_IDLE_LEVEL, 63);
        random_phase(150);
        drain();

        write_reg(mfs_pkg::CFG_SLICE_BASE, 1);
        write_reg(mfs_pkg::CFG_BOOST_LIMIT, 65535);
        write_reg(mfs_pkg::CFG_IDLE_LEVEL, 0);
        // receiver holds off while the sender keeps offering
        random_phase(200);
        hold_req = 1;
        drain();

        write_reg(mfs_pkg::CFG_SLICE_BASE, $urandom_range(1, 255));
        write_reg(mfs_pkg::CFG_BOOST_LIMIT, $urandom_range(50, 400));
        write_reg(mfs_pkg::CFG_IDLE_LEVEL, $urandom_range(1, 60));
        random_phase(380);
        drain();

        if (fail_count == 0) $display("Test completed successfully");
        else $display("Test completed with failures");
        $finish;
    end
endmodule
